>>> sv/one_wire_bus_master_unit_assert.svh
`ifndef ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OWBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/owbm_pkg.sv
package owbm_pkg;

	localparam int CFG_COUNT = 8;
	localparam int CFG_W = 16;
	localparam int ADDR_W = 5;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int BITS_PER_BYTE = 8;
	localparam logic [2:0] BIT_LAST = 3'(BITS_PER_BYTE - 1);
	localparam logic [CFG_W-1:0] READ_PAUSE_TICKS = 16'd55;

	localparam int REG_RESET_LOW = 0;
	localparam int REG_PRES_WAIT = 1;
	localparam int REG_WR0_LOW = 2;
	localparam int REG_WR1_LOW = 3;
	localparam int REG_WR1_PAUSE = 4;
	localparam int REG_RD_LOW = 5;
	localparam int REG_RD_SAMPLE = 6;
	localparam int REG_SLOT_GAP = 7;

	localparam logic [CFG_W-1:0] CFG_DEFAULTS [CFG_COUNT] = '{
		16'd480, 16'd70, 16'd60, 16'd6, 16'd64, 16'd6, 16'd9, 16'd1
	};

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_INIT  = 3'd1,
		OP_RESET = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INIT_LOW  = 2'd1,
		ST_NO_PRES   = 2'd2,
		ST_STUCK_LOW = 2'd3
	} status_t;

	typedef enum logic [10:0] {
		PH_IDLE     = 11'b000_0000_0001,
		PH_RST_LOW  = 11'b000_0000_0010,
		PH_RST_PRES = 11'b000_0000_0100,
		PH_RST_REC  = 11'b000_0000_1000,
		PH_WR_LOW   = 11'b000_0001_0000,
		PH_WR_PAUSE = 11'b000_0010_0000,
		PH_WR_GAP   = 11'b000_0100_0000,
		PH_RD_LOW   = 11'b000_1000_0000,
		PH_RD_SAMP  = 11'b001_0000_0000,
		PH_RD_PAUSE = 11'b010_0000_0000,
		PH_RD_GAP   = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		phase_t     ph;
		logic [2:0] bi;
		logic [7:0] sh;
		logic       fin;
		logic       drive;
	} byte_res_t;

endpackage

>>> sv/one_wire_bus_master_unit.sv
// channel  | dir | handshake          | payload
// s        | in  | s_tvalid/s_tready  | s_tuser opcode, s_tdata data_byte + line_level
// m        | out | m_tvalid/m_tready  | m_tdata drive_low, busy, done, status, read_data
// apb      | in  | psel/penable       | paddr, pwdata, prdata
//
// one request per clock sustained while m_tready holds; each request passes an input
// register and the per-tick phase update into the result register
// zero-length phases are resolved within the same tick by priority logic
// arst_n clears the phase state, status, read byte and both valid bits and loads
// the default durations
// a stalled result holds the input register, which then holds s_tready low
module one_wire_bus_master_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [owbm_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte, [8] line_level
	input  logic [2:0]                      s_tuser,  // [2:0] opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [4:3] status, [12:5] read_data
	output logic [owbm_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [owbm_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import owbm_pkg::*;

	localparam int DW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	logic [CFG_W-1:0] cfg_q [CFG_COUNT];
	logic [7:0] nzv;

	logic valid_s1;
	logic [2:0] op_s1;
	logic [7:0] data_s1;
	logic line_s1;
	logic advance;

	phase_t phase_q;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [2:0] bit_q;
	logic [7:0] shift_q;
	logic [7:0] rx_q;
	status_t status_q;

	logic m_valid_q;
	logic out_drive_q;
	logic out_busy_q;
	logic out_done_q;
	logic [1:0] out_status_q;
	logic [7:0] out_rdata_q;

	phase_t nphase;
	logic [COUNT_WIDTH-1:0] ntick;
	logic [2:0] nbit;
	logic [7:0] nshift;
	logic [7:0] nrx;
	status_t nstatus;
	logic ndone;
	logic ndrive;

	logic [CFG_W-1:0] dcur;
	logic [DW-1:0] dclip;
	logic [DW-1:0] tick_ext;

	logic do_settle;
	phase_t sp;
	logic [2:0] sb;
	logic [7:0] ss;
	logic fin;
	status_t fin_st;
	logic sp_rd;
	logic [1:0] sp_pos;
	byte_res_t br;

	localparam logic RP_NZ = (READ_PAUSE_TICKS != '0);

	function automatic byte_res_t settle_byte(input logic rd, input logic [1:0] pos,
			input logic [2:0] b, input logic [7:0] s, input logic line,
			input logic [7:0] nz);
		byte_res_t r;
		logic [3:0] slot;
		logic found;
		logic [2:0] k_hit;
		logic [1:0] j_hit;
		logic [7:0] sh;
		found = 1'b0;
		k_hit = b;
		j_hit = 2'd0;
		sh = s;
		for (int k = 0; k < BITS_PER_BYTE; k++) begin
			if (!found && (3'(k) >= b)) begin
				if (rd)
					slot = {nz[REG_SLOT_GAP], RP_NZ, nz[REG_RD_SAMPLE], nz[REG_RD_LOW]};
				else
					slot = {1'b0, nz[REG_SLOT_GAP], s[k] & nz[REG_WR1_PAUSE],
						s[k] ? nz[REG_WR1_LOW] : nz[REG_WR0_LOW]};
				for (int j = 0; j < 4; j++) begin
					if (!found && ((3'(k) != b) || (2'(j) >= pos)) && slot[j]) begin
						found = 1'b1;
						k_hit = 3'(k);
						j_hit = 2'(j);
					end
				end
				// the sample slot was passed through inside this bit
				if (rd && line && ((3'(k) != b) || (pos <= 2'd1))
						&& (!found || (j_hit >= 2'd2)))
					sh[k] = 1'b1;
			end
		end
		r.sh = sh;
		r.fin = !found;
		r.bi = found ? k_hit : BIT_LAST;
		r.drive = found && (j_hit == 2'd0);
		if (!found)
			r.ph = PH_IDLE;
		else if (rd) begin
			case (j_hit)
				2'd0: r.ph = PH_RD_LOW;
				2'd1: r.ph = PH_RD_SAMP;
				2'd2: r.ph = PH_RD_PAUSE;
				default: r.ph = PH_RD_GAP;
			endcase
		end else begin
			case (j_hit)
				2'd0: r.ph = PH_WR_LOW;
				2'd1: r.ph = PH_WR_PAUSE;
				default: r.ph = PH_WR_GAP;
			endcase
		end
		return r;
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign prdata = 32'(cfg_q[paddr[4:2]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++)
				cfg_q[i] <= CFG_DEFAULTS[i];
		end else if (psel && penable && pwrite) begin
			cfg_q[paddr[4:2]] <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < CFG_COUNT; i++)
			nzv[i] = (cfg_q[i] != '0);
	end

	// handshake
	assign advance = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			data_s1 <= s_tdata[7:0];
			line_s1 <= s_tdata[8];
		end
	end

	// duration of the running phase
	always_comb begin
		unique case (phase_q)
			PH_RST_LOW, PH_RST_REC: dcur = cfg_q[REG_RESET_LOW];
			PH_RST_PRES: dcur = cfg_q[REG_PRES_WAIT];
			PH_WR_LOW: dcur = shift_q[bit_q] ? cfg_q[REG_WR1_LOW] : cfg_q[REG_WR0_LOW];
			PH_WR_PAUSE: dcur = cfg_q[REG_WR1_PAUSE];
			PH_RD_LOW: dcur = cfg_q[REG_RD_LOW];
			PH_RD_SAMP: dcur = cfg_q[REG_RD_SAMPLE];
			PH_RD_PAUSE: dcur = READ_PAUSE_TICKS;
			PH_WR_GAP, PH_RD_GAP: dcur = cfg_q[REG_SLOT_GAP];
			default: dcur = '0;
		endcase
		dclip = DW'(dcur);
		if (dclip > DW'({COUNT_WIDTH{1'b1}}))
			dclip = DW'({COUNT_WIDTH{1'b1}});
		tick_ext = DW'(tick_q);
	end

	// per-tick update
	always_comb begin
		nphase = phase_q;
		ntick = tick_q;
		nbit = bit_q;
		nshift = shift_q;
		nrx = rx_q;
		nstatus = status_q;
		ndone = 1'b0;
		ndrive = 1'b0;
		do_settle = 1'b0;
		sp = PH_IDLE;
		sb = bit_q;
		ss = shift_q;
		fin = 1'b0;
		fin_st = ST_OK;
		sp_rd = 1'b0;
		sp_pos = 2'd0;
		br = '0;

		if (phase_q == PH_IDLE) begin
			unique case (opcode_t'(op_s1))
				OP_INIT: begin
					if (!line_s1) begin
						fin = 1'b1;
						fin_st = ST_INIT_LOW;
					end else begin
						do_settle = 1'b1;
						sp = PH_RST_LOW;
					end
				end
				OP_RESET: begin
					do_settle = 1'b1;
					sp = PH_RST_LOW;
				end
				OP_WRITE: begin
					do_settle = 1'b1;
					sp = PH_WR_LOW;
					sb = 3'd0;
					ss = data_s1;
				end
				OP_READ: begin
					do_settle = 1'b1;
					sp = PH_RD_LOW;
					sb = 3'd0;
					ss = 8'd0;
				end
				default: ;
			endcase
		end else if (tick_ext < dclip) begin
			ntick = tick_q + COUNT_WIDTH'(1);
			ndrive = (phase_q == PH_RST_LOW) || (phase_q == PH_WR_LOW)
				|| (phase_q == PH_RD_LOW);
		end else begin
			do_settle = 1'b1;
			unique case (phase_q)
				PH_RST_LOW: sp = PH_RST_PRES;
				PH_RST_PRES: begin
					if (line_s1) begin
						do_settle = 1'b0;
						fin = 1'b1;
						fin_st = ST_NO_PRES;
					end else begin
						sp = PH_RST_REC;
					end
				end
				PH_RST_REC: begin
					do_settle = 1'b0;
					fin = 1'b1;
					fin_st = line_s1 ? ST_OK : ST_STUCK_LOW;
				end
				PH_WR_LOW: sp = shift_q[bit_q] ? PH_WR_PAUSE : PH_WR_GAP;
				PH_WR_PAUSE: sp = PH_WR_GAP;
				PH_RD_LOW: sp = PH_RD_SAMP;
				PH_RD_SAMP: begin
					sp = PH_RD_PAUSE;
					ss[bit_q] = shift_q[bit_q] | line_s1;
				end
				PH_RD_PAUSE: sp = PH_RD_GAP;
				PH_WR_GAP, PH_RD_GAP: begin
					if (bit_q == BIT_LAST) begin
						do_settle = 1'b0;
						fin = 1'b1;
						fin_st = ST_OK;
						if (phase_q == PH_RD_GAP)
							nrx = shift_q;
					end else begin
						sb = 3'(bit_q + 3'd1);
						sp = (phase_q == PH_RD_GAP) ? PH_RD_LOW : PH_WR_LOW;
					end
				end
				default: begin
					do_settle = 1'b0;
					nphase = PH_IDLE;
					ntick = '0;
				end
			endcase
		end

		// skip phases of zero length, stop in the first one that takes a tick
		if (do_settle) begin
			nbit = sb;
			nshift = ss;
			unique case (sp)
				PH_RST_LOW, PH_RST_PRES, PH_RST_REC: begin
					if ((sp == PH_RST_LOW) && nzv[REG_RESET_LOW]) begin
						nphase = PH_RST_LOW;
						ndrive = 1'b1;
					end else if ((sp != PH_RST_REC) && nzv[REG_PRES_WAIT]) begin
						nphase = PH_RST_PRES;
					end else if ((sp != PH_RST_REC) && line_s1) begin
						fin = 1'b1;
						fin_st = ST_NO_PRES;
					end else if (nzv[REG_RESET_LOW]) begin
						nphase = PH_RST_REC;
					end else begin
						fin = 1'b1;
						fin_st = line_s1 ? ST_OK : ST_STUCK_LOW;
					end
					if (!fin)
						ntick = COUNT_WIDTH'(1);
				end
				default: begin
					sp_rd = (sp == PH_RD_LOW) || (sp == PH_RD_SAMP)
						|| (sp == PH_RD_PAUSE) || (sp == PH_RD_GAP);
					if ((sp == PH_WR_PAUSE) || (sp == PH_RD_SAMP))
						sp_pos = 2'd1;
					else if ((sp == PH_WR_GAP) || (sp == PH_RD_PAUSE))
						sp_pos = 2'd2;
					else if (sp == PH_RD_GAP)
						sp_pos = 2'd3;
					else
						sp_pos = 2'd0;
					br = settle_byte(sp_rd, sp_pos, sb, ss, line_s1, nzv);
					nbit = br.bi;
					nshift = br.sh;
					if (br.fin) begin
						fin = 1'b1;
						fin_st = ST_OK;
						if (sp_rd)
							nrx = br.sh;
					end else begin
						nphase = br.ph;
						ntick = COUNT_WIDTH'(1);
						ndrive = br.drive;
					end
				end
			endcase
		end

		if (fin) begin
			nphase = PH_IDLE;
			ntick = '0;
			nstatus = fin_st;
			ndone = 1'b1;
			ndrive = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			rx_q <= '0;
			status_q <= ST_OK;
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q <= nphase;
				tick_q <= ntick;
				bit_q <= nbit;
				shift_q <= nshift;
				rx_q <= nrx;
				status_q <= nstatus;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_drive_q <= ndrive;
			out_busy_q <= (nphase != PH_IDLE);
			out_done_q <= ndone;
			out_status_q <= nstatus;
			out_rdata_q <= nrx;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {3'b000, out_rdata_q, out_status_q, out_done_q, out_busy_q, out_drive_q};

	`include "one_wire_bus_master_unit_assert.svh"

	`OWBM_ASSERT_NOW(a_idle_tick_clear, phase_q == PH_IDLE, tick_q == '0, "idle with running tick count")
	`OWBM_ASSERT_NOW(a_busy_tick_set, phase_q != PH_IDLE, tick_q != '0, "busy phase without a counted tick")
	`OWBM_ASSERT_NOW(a_done_not_busy, m_valid_q && out_done_q, !out_busy_q, "done while still busy")
	`OWBM_ASSERT_NOW(a_drive_busy, m_valid_q && out_drive_q, out_busy_q, "line driven while idle")

endmodule

>>> bench/one_wire_bus_master_unit_test.sv
module one_wire_bus_master_unit_test;
	import owbm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SCRIPT_LEN = 17;

	typedef struct packed {
		logic [7:0] rd;
		status_t    st;
		logic       done;
		logic       busy;
		logic       drive;
	} bus_resp_t;

	// how the emulated bus answers while a command runs
	typedef enum logic [1:0] {
		LN_SLAVE,
		LN_OPEN,
		LN_STUCK,
		LN_NOISE
	} line_mode_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data;
		logic       line;
		logic       hold;
		line_mode_t mode;
		logic       chk;
		bus_resp_t  resp;
	} step_row_t;

	localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
		'{OP_TICK,  8'h00, 1'b1, 1'b0, LN_SLAVE, 1'b1, '0},
		'{3'd5,     8'hFF, 1'b0, 1'b0, LN_SLAVE, 1'b1, '0},
		'{3'd6,     8'h00, 1'b1, 1'b0, LN_SLAVE, 1'b1, '0},
		'{3'd7,     8'h5A, 1'b0, 1'b0, LN_SLAVE, 1'b1, '0},
		'{OP_INIT,  8'h00, 1'b0, 1'b0, LN_SLAVE, 1'b1, '{8'h00, ST_INIT_LOW, 1'b1, 1'b0, 1'b0}},
		'{OP_INIT,  8'h00, 1'b1, 1'b1, LN_OPEN,  1'b0, '0},
		'{OP_RESET, 8'h00, 1'b0, 1'b1, LN_STUCK, 1'b0, '0},
		'{OP_RESET, 8'h00, 1'b1, 1'b1, LN_SLAVE, 1'b0, '0},
		'{OP_INIT,  8'h00, 1'b1, 1'b1, LN_SLAVE, 1'b0, '0},
		'{OP_WRITE, 8'h00, 1'b1, 1'b1, LN_SLAVE, 1'b0, '0},
		'{OP_WRITE, 8'hFF, 1'b1, 1'b1, LN_SLAVE, 1'b0, '0},
		'{OP_WRITE, 8'hA5, 1'b1, 1'b0, LN_SLAVE, 1'b0, '0},
		'{OP_READ,  8'h00, 1'b1, 1'b0, LN_SLAVE, 1'b0, '0},
		'{OP_INIT,  8'h00, 1'b0, 1'b0, LN_SLAVE, 1'b0, '0},
		'{OP_TICK,  8'h00, 1'b1, 1'b1, LN_SLAVE, 1'b0, '0},
		'{OP_READ,  8'h00, 1'b1, 1'b1, LN_SLAVE, 1'b0, '0},
		'{OP_RESET, 8'hC3, 1'b0, 1'b1, LN_NOISE, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] data_byte, [8] line_level
	logic [2:0]  s_tuser;   // [2:0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status, [12:5] read_data
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	one_wire_bus_master_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bus master state as the bench sees it
	phase_t      ow_phase;
	logic [15:0] ow_count;
	logic [2:0]  ow_bit;
	logic [7:0]  ow_shift;
	logic [7:0]  ow_rx;
	status_t     ow_status;
	logic        ow_done;
	logic [15:0] dur_cfg [CFG_COUNT];

	bus_resp_t   pending_resp [$];
	logic [7:0]  slave_byte;
	int          items_sent;
	int          idle_cycles;
	bit          fail_seen;
	bit          calm;
	bit          hold_off_req;

	function automatic logic [15:0] phase_ticks();
		case (ow_phase)
		PH_RST_LOW, PH_RST_REC: return dur_cfg[REG_RESET_LOW];
		PH_RST_PRES: return dur_cfg[REG_PRES_WAIT];
		PH_WR_LOW: return ow_shift[ow_bit] ? dur_cfg[REG_WR1_LOW] : dur_cfg[REG_WR0_LOW];
		PH_WR_PAUSE: return dur_cfg[REG_WR1_PAUSE];
		PH_RD_LOW: return dur_cfg[REG_RD_LOW];
		PH_RD_SAMP: return dur_cfg[REG_RD_SAMPLE];
		PH_RD_PAUSE: return READ_PAUSE_TICKS;
		PH_WR_GAP, PH_RD_GAP: return dur_cfg[REG_SLOT_GAP];
		default: return '0;
		endcase
	endfunction

	task automatic enter(input phase_t p);
		ow_phase = p;
		ow_count = '0;
	endtask

	task automatic conclude(input status_t s);
		ow_status = s;
		ow_done = 1'b1;
		enter(PH_IDLE);
	endtask

	task automatic bus_step(input logic [2:0] op, input logic [7:0] data, input logic line,
			output bus_resp_t r);
		logic drv;
		logic waiting;
		int guard;
		drv = 1'b0;
		waiting = 1'b0;
		ow_done = 1'b0;
		if (ow_phase == PH_IDLE) begin
			case (op)
			OP_INIT: begin
				if (!line)
					conclude(ST_INIT_LOW);
				else
					enter(PH_RST_LOW);
			end
			OP_RESET: enter(PH_RST_LOW);
			OP_WRITE: begin
				ow_shift = data;
				ow_bit = '0;
				enter(PH_WR_LOW);
			end
			OP_READ: begin
				ow_shift = '0;
				ow_bit = '0;
				enter(PH_RD_LOW);
			end
			default: ;
			endcase
		end
		// zero-length phases fall through within the same tick
		for (guard = 0; guard < 64 && ow_phase != PH_IDLE && !waiting; guard++) begin
			if (ow_count < phase_ticks()) begin
				ow_count++;
				waiting = 1'b1;
				drv = (ow_phase == PH_RST_LOW) || (ow_phase == PH_WR_LOW) ||
					(ow_phase == PH_RD_LOW);
			end else begin
				case (ow_phase)
				PH_RST_LOW: enter(PH_RST_PRES);
				PH_RST_PRES: begin
					if (line)
						conclude(ST_NO_PRES);
					else
						enter(PH_RST_REC);
				end
				PH_RST_REC: begin
					if (line)
						conclude(ST_OK);
					else
						conclude(ST_STUCK_LOW);
				end
				PH_WR_LOW: begin
					if (ow_shift[ow_bit])
						enter(PH_WR_PAUSE);
					else
						enter(PH_WR_GAP);
				end
				PH_WR_PAUSE: enter(PH_WR_GAP);
				PH_RD_LOW: enter(PH_RD_SAMP);
				PH_RD_SAMP: begin
					if (line)
						ow_shift[ow_bit] = 1'b1;
					enter(PH_RD_PAUSE);
				end
				PH_RD_PAUSE: enter(PH_RD_GAP);
				PH_WR_GAP, PH_RD_GAP: begin
					if (ow_bit == BIT_LAST) begin
						if (ow_phase == PH_RD_GAP)
							ow_rx = ow_shift;
						conclude(ST_OK);
					end else begin
						ow_bit++;
						if (ow_phase == PH_WR_GAP)
							enter(PH_WR_LOW);
						else
							enter(PH_RD_LOW);
					end
				end
				default: enter(PH_IDLE);
				endcase
			end
		end
		r.drive = drv;
		r.busy = (ow_phase != PH_IDLE);
		r.done = ow_done;
		r.st = ow_status;
		r.rd = ow_rx;
	endtask

	// emulated slave: presence while reset runs, its byte during read slots
	function automatic logic line_for(input line_mode_t m);
		case (m)
		LN_SLAVE: begin
			if (ow_phase == PH_RST_LOW || ow_phase == PH_RST_PRES)
				return 1'b0;
			else if (ow_phase == PH_RD_LOW || ow_phase == PH_RD_SAMP)
				return slave_byte[ow_bit];
			else
				return 1'b1;
		end
		LN_OPEN: return 1'b1;
		LN_STUCK: return 1'b0;
		default: return 1'($urandom_range(1));
		endcase
	endfunction

	task automatic issue(input logic [2:0] op, input logic [7:0] data, input logic line,
			input logic fixed_on, input bus_resp_t fixed);
		bus_resp_t want;
		if (!calm && $urandom_range(99) < 4) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'b0, line, data};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bus_step(op, data, line, want);
		if (fixed_on)
			want = fixed;
		pending_resp.push_back(want);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle(input line_mode_t m, input bit stray);
		logic [2:0] op;
		while (ow_phase != PH_IDLE) begin
			if (stray && $urandom_range(19) == 0)
				op = 3'($urandom_range(7));
			else
				op = OP_TICK;
			issue(op, 8'($urandom), line_for(m), 1'b0, '0);
		end
	endtask

	task automatic run_traffic(input int n);
		int target;
		int k;
		int pick;
		line_mode_t m;
		logic [2:0] op;
		target = items_sent + n;
		while (items_sent < target) begin
			// reads hold the bus for hundreds of ticks, so they come rarely
			pick = $urandom_range(99);
			if (pick < 6)
				op = OP_READ;
			else if (pick < 88)
				op = 3'($urandom_range(1, 3));
			else
				op = 3'($urandom_range(7));
			k = $urandom_range(9);
			case (k)
			6: m = LN_OPEN;
			7: m = LN_STUCK;
			8, 9: m = LN_NOISE;
			default: m = LN_SLAVE;
			endcase
			slave_byte = 8'($urandom);
			issue(op, 8'($urandom), line_for(m), 1'b0, '0);
			settle(m, 1'b1);
		end
	endtask

	task automatic load_cfg(input logic [15:0] v [CFG_COUNT]);
		int i;
		s_tvalid <= 1'b0;
		while (pending_resp.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		for (i = 0; i < CFG_COUNT; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= ADDR_W'(4 * i);
			pwdata <= {16'($urandom), v[i]};
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			dur_cfg[i] = v[i];
			@(negedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// register read-back
	task automatic check_cfg();
		int i;
		for (i = 0; i < CFG_COUNT; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= ADDR_W'(4 * i);
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata !== 32'(dur_cfg[i])) begin
				$error("prdata: expected %h, got %h", 32'(dur_cfg[i]), prdata);
				fail_seen = 1'b1;
			end
			@(negedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// response side
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (60) @(negedge clk);
			end
			m_tready <= calm || ($urandom_range(99) >= 8);
		end
	end

	always @(posedge clk) begin
		bus_resp_t want;
		bus_resp_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = bus_resp_t'(m_tdata[12:0]);
			if (pending_resp.size() == 0) begin
				$error("response with none pending: %h", m_tdata);
				fail_seen = 1'b1;
			end else begin
				want = pending_resp.pop_front();
				if (got.drive !== want.drive) begin
					$error("drive_low: expected %0d, got %0d", want.drive, got.drive);
					fail_seen = 1'b1;
				end
				if (got.busy !== want.busy) begin
					$error("busy_res: expected %0d, got %0d", want.busy, got.busy);
					fail_seen = 1'b1;
				end
				if (got.done !== want.done) begin
					$error("done_res: expected %0d, got %0d", want.done, got.done);
					fail_seen = 1'b1;
				end
				if (got.st !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, got.st);
					fail_seen = 1'b1;
				end
				if (got.rd !== want.rd) begin
					$error("read_data: expected %h, got %h", want.rd, got.rd);
					fail_seen = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] vals [CFG_COUNT];
		int i;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		idle_cycles = 0;
		items_sent = 0;
		fail_seen = 1'b0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		dur_cfg = CFG_DEFAULTS;
		ow_phase = PH_IDLE;
		ow_count = '0;
		ow_bit = '0;
		ow_shift = '0;
		ow_rx = '0;
		ow_status = ST_OK;
		ow_done = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default durations after reset
		check_cfg();

		// directed requests at short timing
		vals = '{16'd5, 16'd3, 16'd4, 16'd2, 16'd3, 16'd2, 16'd3, 16'd1};
		load_cfg(vals);
		for (i = 0; i < SCRIPT_LEN; i++) begin
			slave_byte = 8'($urandom);
			issue(SCRIPT[i].op, SCRIPT[i].data, SCRIPT[i].line, SCRIPT[i].chk,
				SCRIPT[i].resp);
			if (SCRIPT[i].hold)
				settle(SCRIPT[i].mode, 1'b0);
		end

		// every configurable phase skipped; the read pause keeps its fixed length
		for (i = 0; i < CFG_COUNT; i++)
			vals[i] = '0;
		load_cfg(vals);
		run_traffic(140);

		// shortest phases, with a long output stall up front
		for (i = 0; i < CFG_COUNT; i++)
			vals[i] = 16'd1;
		load_cfg(vals);
		hold_off_req = 1'b1;
		run_traffic(230);

		for (i = 0; i < CFG_COUNT; i++)
			vals[i] = 16'($urandom_range(6));
		load_cfg(vals);
		calm = 1'b1;
		run_traffic(230);
		calm = 1'b0;

		for (i = 0; i < CFG_COUNT; i++)
			vals[i] = 16'($urandom_range(3));
		load_cfg(vals);
		run_traffic(330);

		// longer reset and pause timing
		for (i = 0; i < CFG_COUNT; i++)
			vals[i] = 16'($urandom_range(2));
		vals[REG_RESET_LOW] = 16'd40;
		vals[REG_PRES_WAIT] = 16'd30;
		vals[REG_WR1_PAUSE] = 16'd25;
		load_cfg(vals);
		check_cfg();
		slave_byte = 8'($urandom);
		issue(OP_RESET, 8'h00, line_for(LN_SLAVE), 1'b0, '0);
		settle(LN_SLAVE, 1'b0);
		issue(OP_WRITE, 8'h80, 1'b1, 1'b0, '0);
		settle(LN_SLAVE, 1'b0);

		s_tvalid <= 1'b0;
		while (pending_resp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (!fail_seen && pending_resp.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
